[hdl/psu_pkg.sv]
// psu_pkg: types, stage schedule and per-stage datapath functions of the
// particle swelling update pipeline. No dependencies.
package psu_pkg;

  localparam logic [2:0] REG_SWELL_RATE  = 3'd0;
  localparam logic [2:0] REG_DELAY_SCALE = 3'd1;
  localparam logic [2:0] REG_MIN_TEMP    = 3'd2;
  localparam logic [2:0] REG_REF_TEMP    = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [15:0] RATIO_ONE = 16'd4096;
  localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

  // stage schedule
  localparam int ST_SQRT_N = 25;
  localparam int ST_LOG_N  = 32;
  localparam int ST_NL     = 32;
  localparam int ST_MULA   = 33;
  localparam int ST_MULB   = 38;
  localparam int ST_SEL    = 43;
  localparam int ST_DIV    = 44;
  localparam int ST_SW     = 108;
  localparam int ST_M1     = 109;
  localparam int ST_M2     = 114;
  localparam int ST_M3     = 119;
  localparam int ST_M4     = 124;
  localparam int ST_M5     = 129;
  localparam int ST_RAD    = 134;
  localparam int ST_M6     = 135;
  localparam int NST       = 140;
  localparam int LATENCY   = NST + 2;

  typedef struct packed {
    logic [31:0] swell_rate;
    logic [47:0] delay_scale;
    logic [31:0] min_temp;
    logic [31:0] ref_temp;
    logic [31:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic [47:0]  delay;
    logic [31:0]  s;
    logic [31:0]  r0;
    logic [31:0]  rad;
    logic [15:0]  ratio;
    logic [31:0]  diff;
    logic         tgt;
    logic         bad;
    logic         act;
    logic         neg;
    logic [4:0]   e;
    logic [31:0]  frac;
    logic [31:0]  x;
    logic [48:0]  sv;
    logic [49:0]  sres;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [127:0] acc;
    logic [63:0]  divd;
    logic [31:0]  rem;
    logic [63:0]  q;
    logic [31:0]  ns;
  } item_t;

  // one 32x32 partial product of a*b, added at its weight
  function automatic logic [127:0] mul_part(item_t it, int p);
    logic [63:0] prod;
    int ai;
    int bi;
    ai = p >> 1;
    bi = p & 1;
    prod = {32'b0, it.a[32*ai +: 32]} * {32'b0, it.b[32*bi +: 32]};
    return it.acc + (128'(prod) << (32 * (ai + bi)));
  endfunction

  // product shifted right, saturating at all ones
  function automatic logic [63:0] mul_fin(logic [127:0] acc, int sh);
    if ((acc >> (64 + sh)) != '0) return '1;
    return 64'(acc >> sh);
  endfunction

  function automatic logic in_mul(int k, int base);
    return (k >= base) && (k < base + 4);
  endfunction

  function automatic item_t stage_fn(int k, item_t it, cfg_t c);
    item_t       o;
    logic [63:0] sqr;
    logic [32:0] y;
    logic [50:0] bitv;
    logic [50:0] trial;
    logic [32:0] rtr;
    logic [32:0] dd;
    logic [15:0] ad;
    int          j;
    o = it;
    if (k < ST_LOG_N) begin
      // log2 fraction: square mantissa, shift out one bit
      sqr = {32'b0, it.x} * {32'b0, it.x};
      y = sqr[63:31];
      o.frac = {it.frac[30:0], y[32]};
      o.x = y[32] ? y[32:1] : y[31:0];
      if (k < ST_SQRT_N) begin
        bitv = 51'd1 << (2 * (ST_SQRT_N - 1 - k));
        trial = {1'b0, it.sres} + bitv;
        if ({2'b0, it.sv} >= trial) begin
          o.sv = 49'({2'b0, it.sv} - trial);
          o.sres = 50'(({1'b0, it.sres} >> 1) + bitv);
        end else begin
          o.sres = it.sres >> 1;
        end
      end
    end else if (k == ST_NL) begin
      o.a = (64'd16 << 32) - ((64'(it.e) << 32) | 64'(it.frac));
      o.b = LN2_Q32;
      o.acc = '0;
    end else if (in_mul(k, ST_MULA)) begin
      o.acc = mul_part(it, k - ST_MULA);
    end else if (k == ST_MULA + 4) begin
      o.a = mul_fin(it.acc, 32);
      o.b = {16'b0, c.delay_scale};
      o.acc = '0;
    end else if (in_mul(k, ST_MULB)) begin
      o.acc = mul_part(it, k - ST_MULB);
    end else if (k == ST_MULB + 4) begin
      o.a = mul_fin(it.acc, 32);
    end else if (k == ST_SEL) begin
      o.act = !it.bad && (it.a < {16'b0, it.delay});
      o.divd = o.act ? {it.diff, 32'b0} : {32'b0, it.diff} * {32'b0, c.time_step};
      o.rem = '0;
      o.q = '0;
    end else if ((k >= ST_DIV) && (k < ST_SW)) begin
      // one quotient bit per stage
      j = 63 - (k - ST_DIV);
      rtr = {it.rem, it.divd[j]};
      dd = {1'b0, 32'(c.ref_temp - c.min_temp)};
      if (rtr >= dd) begin
        o.rem = 32'(rtr - dd);
        o.q[j] = 1'b1;
      end else begin
        o.rem = rtr[31:0];
      end
    end else if (k == ST_SW) begin
      o.a = 64'(33'h1_0000_0000 - {1'b0, it.s});
      o.b = 64'(it.sres);
      o.acc = '0;
    end else if (in_mul(k, ST_M1)) begin
      o.acc = mul_part(it, k - ST_M1);
    end else if (k == ST_M1 + 4) begin
      o.a = mul_fin(it.acc, 24);
      o.b = {32'b0, c.time_step};
      o.acc = '0;
    end else if (in_mul(k, ST_M2)) begin
      o.acc = mul_part(it, k - ST_M2);
    end else if (k == ST_M2 + 4) begin
      o.a = mul_fin(it.acc, 32);
      o.b = {32'b0, c.swell_rate};
      o.acc = '0;
    end else if (in_mul(k, ST_M3)) begin
      o.acc = mul_part(it, k - ST_M3);
    end else if (k == ST_M3 + 4) begin
      o.a = mul_fin(it.acc, 16);
      o.b = it.q;
      o.acc = '0;
    end else if (in_mul(k, ST_M4)) begin
      o.acc = mul_part(it, k - ST_M4);
    end else if (k == ST_M4 + 4) begin
      o.a = mul_fin(it.acc, 32);
      o.b = it.q;
      o.acc = '0;
    end else if (in_mul(k, ST_M5)) begin
      o.acc = mul_part(it, k - ST_M5);
    end else if (k == ST_M5 + 4) begin
      o.a = mul_fin(it.acc, 32);
    end else if (k == ST_RAD) begin
      o.ns = (it.a >= {32'b0, MAX32 - it.s}) ? MAX32 : 32'(it.s + it.a[31:0]);
      o.neg = it.ratio < RATIO_ONE;
      ad = o.neg ? RATIO_ONE - it.ratio : it.ratio - RATIO_ONE;
      o.a = {32'b0, it.r0} * {48'b0, ad};
      o.b = {32'b0, o.ns};
      o.acc = '0;
    end else if (in_mul(k, ST_M6)) begin
      o.acc = mul_part(it, k - ST_M6);
    end else if (k == ST_M6 + 4) begin
      o.a = mul_fin(it.acc, 44);
    end
    return o;
  endfunction

endpackage

[hdl/particle_swelling_update_unit.sv]
// particle_swelling_update_unit: pipelined particle swelling update with
// APB-style register port. Depends on psu_pkg.
// Throughput one item per cycle. Depth is set by the 32 log squaring stages, the
// 64-stage quotient divider and eight multipliers of five stages each (four partial
// products, one shift). busy is always low. rst_ni clears the configuration registers
// to 0 and drops all items in flight.
module particle_swelling_update_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] difficulty_i,
  input  logic [47:0] delay_elapsed_i,
  input  logic [31:0] swell_level_i,
  input  logic [31:0] temperature_i,
  input  logic [31:0] initial_radius_i,
  input  logic [31:0] current_radius_i,
  input  logic [15:0] swell_ratio_i,
  output logic        valid_o,
  output logic [47:0] new_delay_elapsed_o,
  output logic [31:0] new_swell_level_o,
  output logic [31:0] new_radius_o,
  output logic        swelling_active_o,
  output logic        bad_config_o
);
  import psu_pkg::*;

  logic [31:0] swell_rate_q;
  logic [47:0] delay_scale_q;
  logic [31:0] min_temperature_q;
  logic [31:0] ref_temperature_q;
  logic [31:0] time_step_q;
  cfg_t        cfg;

  item_t       st_q [NST+1];
  logic        vld_q [NST+1];
  item_t       entry;
  logic [16:0] m;
  logic [4:0]  e;
  logic [47:0] xw;

  logic        valid_q;
  logic [47:0] nd_q;
  logic [31:0] ns_q;
  logic [31:0] nr_q;
  logic        act_q;
  logic        bad_q;
  logic [47:0] nd_d;
  logic [31:0] ns_d;
  logic [31:0] nr_d;
  item_t       fin;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swell_rate_q      <= '0;
      delay_scale_q     <= '0;
      min_temperature_q <= '0;
      ref_temperature_q <= '0;
      time_step_q       <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        REG_SWELL_RATE:  swell_rate_q      <= pwdata[31:0];
        REG_DELAY_SCALE: delay_scale_q     <= pwdata[47:0];
        REG_MIN_TEMP:    min_temperature_q <= pwdata[31:0];
        REG_REF_TEMP:    ref_temperature_q <= pwdata[31:0];
        REG_TIME_STEP:   time_step_q       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_SWELL_RATE:  prdata = {32'b0, swell_rate_q};
      REG_DELAY_SCALE: prdata = {16'b0, delay_scale_q};
      REG_MIN_TEMP:    prdata = {32'b0, min_temperature_q};
      REG_REF_TEMP:    prdata = {32'b0, ref_temperature_q};
      REG_TIME_STEP:   prdata = {32'b0, time_step_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{swell_rate: swell_rate_q, delay_scale: delay_scale_q,
                 min_temp: min_temperature_q, ref_temp: ref_temperature_q,
                 time_step: time_step_q};

  // entry: mantissa normalize for the log, sqrt seed, temperature difference
  always_comb begin
    m = 17'h1_0000 - {1'b0, difficulty_i};
    e = '0;
    for (int i = 0; i < 17; i++) begin
      if (m[i]) e = 5'(i);
    end
    xw = {31'b0, m} << (6'd31 - {1'b0, e});
    entry = '0;
    entry.delay = delay_elapsed_i;
    entry.s     = swell_level_i;
    entry.r0    = initial_radius_i;
    entry.rad   = current_radius_i;
    entry.ratio = swell_ratio_i;
    entry.diff  = (temperature_i >= min_temperature_q) ?
                  temperature_i - min_temperature_q : min_temperature_q - temperature_i;
    entry.tgt   = temperature_i > min_temperature_q;
    entry.bad   = ref_temperature_q <= min_temperature_q;
    entry.e     = e;
    entry.x     = xw[31:0];
    entry.sv    = {m, 32'b0};
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else vld_q[0] <= start && !busy;
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      st_q[k+1] <= stage_fn(k, st_q[k], cfg);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else vld_q[k+1] <= vld_q[k];
    end
  end

  // result select and saturation
  always_comb begin
    fin  = st_q[NST];
    nd_d = fin.delay;
    ns_d = fin.s;
    nr_d = fin.rad;
    if (fin.act) begin
      ns_d = fin.ns;
      if (!fin.neg) begin
        nr_d = (fin.a >= {32'b0, MAX32 - fin.r0}) ? MAX32 : 32'(fin.r0 + fin.a[31:0]);
      end else begin
        nr_d = (fin.a >= {32'b0, fin.r0}) ? '0 : 32'(fin.r0 - fin.a[31:0]);
      end
    end else if (!fin.bad && fin.tgt) begin
      nd_d = (fin.q >= {16'b0, MAX48 - fin.delay}) ? MAX48 : 48'(fin.delay + fin.q[47:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    nd_q  <= nd_d;
    ns_q  <= ns_d;
    nr_q  <= nr_d;
    act_q <= fin.act;
    bad_q <= fin.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= vld_q[NST];
  end

  assign valid_o             = valid_q;
  assign new_delay_elapsed_o = nd_q;
  assign new_swell_level_o   = ns_q;
  assign new_radius_o        = nr_q;
  assign swelling_active_o   = act_q;
  assign bad_config_o        = bad_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY valid_o)
    else $error("item result missing after pipeline latency");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(bad_config_o && swelling_active_o))
    else $error("swelling applied under bad configuration");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bad_config_o |-> ref_temperature_q <= min_temperature_q)
    else $error("bad configuration flag without bad temperatures");
`endif

endmodule

[tb/tb_particle_swelling_update_unit.sv]
`timescale 1ns / 100ps
// tb_particle_swelling_update_unit: self-checking bench for the particle swelling
// update pipeline: scoreboard class with its own predictor, APB register writes
// between phases, random and directed items. Depends on psu_pkg and the unit.

typedef struct {
  logic [15:0] difficulty;
  logic [47:0] delay;
  logic [31:0] level;
  logic [31:0] temp;
  logic [31:0] r0;
  logic [31:0] rad;
  logic [15:0] ratio;
} particle_t;

typedef struct {
  logic [47:0] delay;
  logic [31:0] level;
  logic [31:0] radius;
  logic        active;
  logic        bad;
} swell_res_t;

class swell_scoreboard;
  logic [31:0] k0, tmin, tref, dt;
  logic [47:0] tau;
  swell_res_t  pending[$];
  int          n_mismatch, n_checked, n_active, n_bad;

  function new();
    k0 = 0; tau = 0; tmin = 0; tref = 0; dt = 0;
    n_mismatch = 0; n_checked = 0; n_active = 0; n_bad = 0;
  endfunction

  static function logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if ((p >> (64 + sh)) != 0) return '1;
    return 64'(p >> sh);
  endfunction

  static function logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // -ln(1-alpha) in Q.32
  static function logic [63:0] neg_log(logic [15:0] alpha);
    logic [63:0] m, x, frac, nl2;
    int e;
    m = 64'd65536 - alpha;
    e = 0;
    frac = 0;
    while ((m >> (e + 1)) != 0) e++;
    x = m << (31 - e);
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    nl2 = (64'd16 << 32) - ((64'(e) << 32) + frac);
    return mul_sat(nl2, psu_pkg::LN2_Q32, 32);
  endfunction

  function logic [63:0] delay_threshold(logic [15:0] alpha);
    return mul_sat(neg_log(alpha), {16'b0, tau}, 32);
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      psu_pkg::REG_SWELL_RATE:  k0 = val[31:0];
      psu_pkg::REG_DELAY_SCALE: tau = val[47:0];
      psu_pkg::REG_MIN_TEMP:    tmin = val[31:0];
      psu_pkg::REG_REF_TEMP:    tref = val[31:0];
      psu_pkg::REG_TIME_STEP:   dt = val[31:0];
      default: ;
    endcase
  endfunction

  function swell_res_t predict(particle_t p);
    swell_res_t  o;
    logic [63:0] d, thr, sq, diff, r, x, inc, pr, t;
    o.delay = p.delay; o.level = p.level; o.radius = p.rad;
    o.active = 0; o.bad = 0;
    if (tref <= tmin) begin
      o.bad = 1;
      return o;
    end
    d = 64'(tref) - 64'(tmin);
    thr = delay_threshold(p.difficulty);
    if (thr < 64'(p.delay)) begin
      sq = root64((64'd65536 - p.difficulty) << 32);
      diff = p.temp >= tmin ? 64'(p.temp - tmin) : 64'(tmin - p.temp);
      r = (diff << 32) / d;
      x = mul_sat(64'h1_0000_0000 - p.level, sq, 24);
      x = mul_sat(x, 64'(dt), 32);
      x = mul_sat(x, 64'(k0), 16);
      x = mul_sat(x, r, 32);
      x = mul_sat(x, r, 32);
      o.level = (x >= 64'(psu_pkg::MAX32 - p.level)) ? psu_pkg::MAX32 : 32'(p.level + x);
      o.active = 1;
      if (p.ratio >= psu_pkg::RATIO_ONE) begin
        pr = 64'(p.r0) * 64'(p.ratio - psu_pkg::RATIO_ONE);
        t = mul_sat(pr, 64'(o.level), 44);
        o.radius = (t >= 64'(psu_pkg::MAX32 - p.r0)) ? psu_pkg::MAX32 : 32'(p.r0 + t);
      end else begin
        pr = 64'(p.r0) * 64'(psu_pkg::RATIO_ONE - p.ratio);
        t = mul_sat(pr, 64'(o.level), 44);
        o.radius = (t >= 64'(p.r0)) ? 32'd0 : 32'(p.r0 - t);
      end
    end else if (p.temp > tmin) begin
      inc = (64'(dt) * 64'(p.temp - tmin)) / d;
      o.delay = (inc >= 64'(psu_pkg::MAX48 - p.delay)) ? psu_pkg::MAX48 : 48'(p.delay + inc);
    end
    return o;
  endfunction

  function void note_item(particle_t p);
    pending.push_back(predict(p));
  endfunction

  function void check_result(swell_res_t got);
    swell_res_t want;
    if (pending.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("unexpected result: delay %h level %h radius %h",
                                     got.delay, got.level, got.radius);
      return;
    end
    want = pending.pop_front();
    n_checked++;
    if (got.active) n_active++;
    if (got.bad) n_bad++;
    if (got.delay !== want.delay || got.level !== want.level ||
        got.radius !== want.radius || got.active !== want.active || got.bad !== want.bad) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch #%0d: exp d=%h s=%h r=%h a=%b b=%b  got d=%h s=%h r=%h a=%b b=%b",
                 n_checked, want.delay, want.level, want.radius, want.active, want.bad,
                 got.delay, got.level, got.radius, got.active, got.bad);
    end
  endfunction
endclass

module tb_particle_swelling_update_unit;
  import psu_pkg::*;

  localparam int WATCHDOG_MAX = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0, pready;
  logic [5:0]  paddr = 0;
  logic [63:0] pwdata = 0, prdata;
  logic        start = 0, busy;
  logic [15:0] difficulty_i = 0, swell_ratio_i = 0;
  logic [47:0] delay_elapsed_i = 0, new_delay_elapsed_o;
  logic [31:0] swell_level_i = 0, temperature_i = 0, initial_radius_i = 0, current_radius_i = 0;
  logic [31:0] new_swell_level_o, new_radius_o;
  logic        valid_o, swelling_active_o, bad_config_o;

  swell_scoreboard sb = new();
  int  idle_pct = 25;
  int  n_sent = 0;
  int  quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  particle_swelling_update_unit dut (.*);

  // outputs sampled mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result('{new_delay_elapsed_o, new_swell_level_o, new_radius_o,
                        swelling_active_o, bad_config_o});
    if ((start && !busy) || valid_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog expired, %0d results outstanding", sb.pending.size());
      $display("[particle_swelling_update_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [31:0] k0, logic [47:0] tau, logic [31:0] tmin,
                             logic [31:0] tref, logic [31:0] dt);
    // drain the pipe first so that no item in flight sees the new setting
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    write_reg(REG_SWELL_RATE, {32'b0, k0});
    write_reg(REG_DELAY_SCALE, {16'b0, tau});
    write_reg(REG_MIN_TEMP, {32'b0, tmin});
    write_reg(REG_REF_TEMP, {32'b0, tref});
    write_reg(REG_TIME_STEP, {32'b0, dt});
  endtask

  task automatic send_item(particle_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    difficulty_i <= p.difficulty; delay_elapsed_i <= p.delay; swell_level_i <= p.level;
    temperature_i <= p.temp; initial_radius_i <= p.r0; current_radius_i <= p.rad;
    swell_ratio_i <= p.ratio;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sb.note_item(p);
    n_sent++;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic particle_t rand_particle();
    particle_t   p;
    logic [63:0] thr;
    int          off;
    p.difficulty = $urandom_range(3) == 0 ? 16'($urandom_range(65535, 65000)) : 16'($urandom);
    p.level = $urandom_range(4) == 0 ? 32'hFFFF_FFFF - $urandom_range(1000) : $urandom;
    p.r0 = $urandom_range(5) == 0 ? 32'hFFFF_FFFF : $urandom;
    p.rad = $urandom;
    case ($urandom_range(3))
      0: p.ratio = 16'($urandom);
      1: p.ratio = RATIO_ONE + 16'($urandom_range(8192));
      2: p.ratio = 16'($urandom_range(4095));
      default: p.ratio = RATIO_ONE;
    endcase
    off = $urandom_range(2000) - 1000;
    case ($urandom_range(3))
      0: p.temp = $urandom;
      1: p.temp = sb.tmin + off;
      2: p.temp = sb.tmin + ((sb.tref - sb.tmin) >> $urandom_range(3));
      default: p.temp = sb.tref + off;
    endcase
    // delay mostly near the swelling threshold so both branches are taken
    thr = sb.delay_threshold(p.difficulty);
    case ($urandom_range(4))
      0: p.delay = rand48();
      1: p.delay = rand48() >> $urandom_range(47);
      default: p.delay = thr > 64'(MAX48) ? MAX48 - $urandom_range(3)
                                          : 48'(thr) + 48'(off);
    endcase
    return p;
  endfunction

  task automatic random_items(int count);
    repeat (count) send_item(rand_particle());
  endtask

  task automatic directed_items();
    particle_t b;
    b = '{16'd100, 48'h1_0000_0000_00, 32'h4000_0000, 32'd350 << 16, 32'h0100_0000,
          32'h0080_0000, 16'd8192};
    send_item(b);
    b.difficulty = 16'd0;           send_item(b);
    b.difficulty = 16'hFFFF;        send_item(b);
    b.difficulty = 16'd100;
    b.delay = 48'd0;                send_item(b);
    b.delay = MAX48;                send_item(b);
    b.level = 32'd0;                send_item(b);
    b.level = 32'hFFFF_FFFF;        send_item(b);
    b.level = 32'h8000_0000;
    b.temp = 32'd0;                 send_item(b);   // cold particle, still swells
    b.temp = 32'hFFFF_FFFF;         send_item(b);
    b.temp = sb.tmin;               send_item(b);
    b.temp = 32'd350 << 16;
    b.ratio = 16'd0;                send_item(b);   // shrinking
    b.ratio = RATIO_ONE;            send_item(b);
    b.ratio = 16'hFFFF;             send_item(b);
    b.r0 = 32'd0;                   send_item(b);
    b.r0 = 32'hFFFF_FFFF;           send_item(b);
    b.rad = 32'd0;                  send_item(b);
    b.rad = 32'hFFFF_FFFF;          send_item(b);
    // delay side below threshold and cold, then extreme difficulty, delay and temperature
    b.delay = 48'd5;                send_item(b);
    b.temp = 32'd1;                 send_item(b);
    b.difficulty = 16'hFFFF; b.delay = MAX48 - 48'd3; b.temp = 32'hFFFF_FFFF;
    send_item(b);
    b.difficulty = 16'd0; b.delay = 48'd0; send_item(b);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    // reset values: every item comes back flagged as a bad setting
    random_items(60);
    load_config(32'd5 << 16, 48'h1_0000_0000, 32'd300 << 16, 32'd400 << 16, 32'h1000_0000);
    write_reg(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);   // unmapped register, must be ignored
    directed_items();
    random_items(250);
    idle_pct = 0;
    load_config(32'hFFFF_FFFF, MAX48, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(200);
    idle_pct = 25;
    load_config(32'd1, 48'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1);
    random_items(150);
    load_config(32'd7 << 16, 48'h8000_0000, 32'd500 << 16, 32'd500 << 16, 32'h100_0000);
    random_items(120);
    load_config($urandom, rand48(), 32'd200 << 16,
                (32'd200 << 16) + 32'($urandom_range(65535)), $urandom);
    directed_items();
    random_items(220);
    load_config(32'd2 << 16, 48'h2_0000_0000, 32'd273 << 16, 32'd1273 << 16, 32'h0400_0000);
    random_items(230);
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d items sent over seven register settings, %0d results checked",
             n_sent, sb.n_checked);
    $display("%0d results swelling, %0d flagged bad setting, %0d mismatches",
             sb.n_active, sb.n_bad, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending.size() == 0)
      $display("[particle_swelling_update_unit] OK");
    else
      $display("[particle_swelling_update_unit] ERROR");
    $finish;
  end
endmodule

[filelist.f]
hdl/psu_pkg.sv
hdl/particle_swelling_update_unit.sv
tb/tb_particle_swelling_update_unit.sv
